// ===== rtl/rcpcm_pkg.sv =====
package rcpcm_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COUNTER_BITS_DEF = 12;
   localparam int RUN_CFG_BITS   = 12;
   localparam int OFFSET_BITS    = 7;
   localparam int CHAN_BITS      = 11;
   localparam int MAG_BITS       = 9;
   localparam int NUM_SYMBOLS    = 23;
   localparam int SYM_BITS       = 3;
   localparam int IDX_BITS       = $clog2(NUM_SYMBOLS);
   localparam int LEVEL_ARG_BITS = 16;
   localparam int NUM_BANDS      = 7;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [RUN_CFG_BITS-1:0] SYNC_RUN_RST      = 12'd62;
   localparam logic [RUN_CFG_BITS-1:0] BIT_THRESHOLD_RST = 12'd17;
   localparam logic signed [OFFSET_BITS-1:0] AIL_OFFSET_RST = 7'sd14;
   localparam logic signed [OFFSET_BITS-1:0] ELE_OFFSET_RST = 7'sd0;
   localparam logic signed [OFFSET_BITS-1:0] THR_OFFSET_RST = -7'sd6;
   localparam logic signed [OFFSET_BITS-1:0] RUD_OFFSET_RST = -7'sd3;

   // lower edges of level bands one to seven
   localparam logic [LEVEL_ARG_BITS-1:0] LEVEL_BANDS [NUM_BANDS] =
      '{16'd17, 16'd21, 16'd25, 16'd29, 16'd33, 16'd36, 16'd40};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SYNC_RUN      = 3'd0,
      CSR_BIT_THRESHOLD = 3'd1,
      CSR_AIL_OFFSET    = 3'd2,
      CSR_ELE_OFFSET    = 3'd3,
      CSR_THR_OFFSET    = 3'd4,
      CSR_RUD_OFFSET    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [NUM_SYMBOLS-1:0][SYM_BITS-1:0] sym;
   } frame_type;

   typedef struct packed {
      logic signed [OFFSET_BITS-1:0] ail;
      logic signed [OFFSET_BITS-1:0] ele;
      logic signed [OFFSET_BITS-1:0] thr;
      logic signed [OFFSET_BITS-1:0] rud;
   } offsets_type;

   function automatic logic [SYM_BITS-1:0] level_of(input logic [LEVEL_ARG_BITS-1:0] n);
      logic [SYM_BITS-1:0] lvl;
      lvl = '0;
      for (int b = 0; b < NUM_BANDS; b++) begin
         if (n >= LEVEL_BANDS[b]) begin
            lvl = SYM_BITS'(b + 1);
         end
      end
      return lvl;
   endfunction

endpackage

// ===== rtl/rc_pcm_audio_frame_decoder_unit.sv =====
// Radio-control PCM frame decoder. One signed audio sample is taken per clock
// cycle, back to back while req_ready is high; the run counters, phase and
// symbol registers update in that single cycle, so the sustained rate is one
// sample per cycle unless the queue is full. The sample that closes a frame (23
// symbols, or a zero sample cutting it short) pushes the frame into a two-entry
// queue; the channel pack and offset adds then register the queue head's result
// onto rsp_. req_ready drops only while the queue holds two frames behind a
// result that has not been taken. Configuration is written through csr_ one
// register a cycle; the symbol store needs no clearing after reset.
module rc_pcm_audio_frame_decoder_unit
   import rcpcm_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [CHAN_BITS-1:0]   rsp_aileron,
   output logic signed [CHAN_BITS-1:0]   rsp_elevator,
   output logic signed [CHAN_BITS-1:0]   rsp_throttle,
   output logic signed [CHAN_BITS-1:0]   rsp_rudder,
   output logic                          rsp_flip_switch,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   logic [RUN_CFG_BITS-1:0] sync_run_ff;
   logic [RUN_CFG_BITS-1:0] bit_threshold_ff;
   offsets_type             offsets_ff;

   logic      push, queue_full, head_valid, pop;
   frame_type push_frame, head_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_run_ff      <= SYNC_RUN_RST;
         bit_threshold_ff <= BIT_THRESHOLD_RST;
         offsets_ff.ail   <= AIL_OFFSET_RST;
         offsets_ff.ele   <= ELE_OFFSET_RST;
         offsets_ff.thr   <= THR_OFFSET_RST;
         offsets_ff.rud   <= RUD_OFFSET_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYNC_RUN:      sync_run_ff      <= csr_wdata[RUN_CFG_BITS-1:0];
            CSR_BIT_THRESHOLD: bit_threshold_ff <= csr_wdata[RUN_CFG_BITS-1:0];
            CSR_AIL_OFFSET:    offsets_ff.ail   <= csr_wdata[OFFSET_BITS-1:0];
            CSR_ELE_OFFSET:    offsets_ff.ele   <= csr_wdata[OFFSET_BITS-1:0];
            CSR_THR_OFFSET:    offsets_ff.thr   <= csr_wdata[OFFSET_BITS-1:0];
            CSR_RUD_OFFSET:    offsets_ff.rud   <= csr_wdata[OFFSET_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   rcpcm_front #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .sync_run      (sync_run_ff),
      .bit_threshold (bit_threshold_ff),
      .queue_full    (queue_full),
      .push          (push),
      .frame         (push_frame)
   );

   rcpcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (queue_full),
      .head_valid (head_valid),
      .pop        (pop),
      .head_frame (head_frame)
   );

   rcpcm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_frame      (head_frame),
      .pop             (pop),
      .offsets         (offsets_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_aileron     (rsp_aileron),
      .rsp_elevator    (rsp_elevator),
      .rsp_throttle    (rsp_throttle),
      .rsp_rudder      (rsp_rudder),
      .rsp_flip_switch (rsp_flip_switch)
   );

endmodule

// ===== rtl/rcpcm_front.sv =====
module rcpcm_front
   import rcpcm_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic [RUN_CFG_BITS-1:0]       sync_run,
   input  logic [RUN_CFG_BITS-1:0]       bit_threshold,
   input  logic                          queue_full,
   output logic                          push,
   output frame_type                     frame
);

   localparam int CmpBits = (COUNTER_BITS > RUN_CFG_BITS) ? COUNTER_BITS : RUN_CFG_BITS;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LOW,
      PH_HIGH
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [COUNTER_BITS-1:0]   high_ff, high_in;
   logic [COUNTER_BITS-1:0]   low_ff, low_in;
   logic [IDX_BITS-1:0]       idx_ff, idx_in;
   logic [SYM_BITS-1:0]       sym_ff [NUM_SYMBOLS];

   logic                      take;
   logic                      neg, zero, pos;
   logic                      run_end, last, finish;
   logic [SYM_BITS-1:0]       ended_sym;
   logic [COUNTER_BITS-1:0]   high_inc, low_inc;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;

   assign neg  = req_sample[SAMPLE_BITS-1];
   assign zero = (req_sample == '0);
   assign pos  = !neg && !zero;

   assign high_inc = (high_ff == '1) ? high_ff : high_ff + 1'b1;
   assign low_inc  = (low_ff == '1) ? low_ff : low_ff + 1'b1;

   assign run_end = ((phase_ff == PH_LOW) && !neg) || ((phase_ff == PH_HIGH) && !pos);
   assign last    = (idx_ff == IDX_BITS'(NUM_SYMBOLS - 1));
   assign finish  = run_end && (last || zero);
   assign push    = take && finish;

   always_comb begin
      if (phase_ff == PH_LOW) begin
         ended_sym = {{(SYM_BITS-1){1'b0}},
                      (CmpBits'(low_ff) >= CmpBits'(bit_threshold))};
      end else begin
         ended_sym = level_of(LEVEL_ARG_BITS'(high_ff));
      end
   end

   // symbols after the ended one are zero when a zero sample cuts the frame
   always_comb begin
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
         if (IDX_BITS'(i) == idx_ff) begin
            frame.sym[i] = ended_sym;
         end else if (IDX_BITS'(i) < idx_ff) begin
            frame.sym[i] = sym_ff[i];
         end else begin
            frame.sym[i] = '0;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      idx_in   = idx_ff;
      case (phase_ff)
         PH_LOW: begin
            if (neg) begin
               low_in = low_inc;
            end else begin
               low_in = '0;
               if (finish) begin
                  phase_in = PH_HUNT;
                  high_in  = (last && pos) ? COUNTER_BITS'(1) : '0;
                  idx_in   = '0;
               end else begin
                  phase_in = PH_HIGH;
                  high_in  = COUNTER_BITS'(1);
                  idx_in   = idx_ff + 1'b1;
               end
            end
         end
         PH_HIGH: begin
            if (pos) begin
               high_in = high_inc;
            end else begin
               high_in = '0;
               if (finish) begin
                  phase_in = PH_HUNT;
                  low_in   = '0;
                  idx_in   = '0;
               end else begin
                  phase_in = PH_LOW;
                  low_in   = COUNTER_BITS'(1);
                  idx_in   = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            if (neg && (CmpBits'(high_ff) >= CmpBits'(sync_run))) begin
               phase_in = PH_LOW;
               high_in  = '0;
               low_in   = COUNTER_BITS'(1);
               idx_in   = '0;
            end else begin
               phase_in = PH_HUNT;
               high_in  = pos ? high_inc : '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         high_ff  <= '0;
         low_ff   <= '0;
         idx_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && run_end) begin
         sym_ff[idx_ff] <= ended_sym;
      end
   end

endmodule

// ===== rtl/rcpcm_queue.sv =====
module rcpcm_queue
   import rcpcm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_frame,
   output logic      full,
   output logic      head_valid,
   input  logic      pop,
   output frame_type head_frame
);

   localparam int PtrBits   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

   frame_type              mem_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CountBits-1:0]   count_ff;
   logic                   do_pop;

   assign full       = (count_ff == CountBits'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_frame = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
      return (p == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// ===== rtl/rcpcm_back.sv =====
module rcpcm_back
   import rcpcm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  frame_type                   head_frame,
   output logic                        pop,
   input  offsets_type                 offsets,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [CHAN_BITS-1:0] rsp_aileron,
   output logic signed [CHAN_BITS-1:0] rsp_elevator,
   output logic signed [CHAN_BITS-1:0] rsp_throttle,
   output logic signed [CHAN_BITS-1:0] rsp_rudder,
   output logic                        rsp_flip_switch
);

   logic                        rsp_valid_ff;
   logic signed [CHAN_BITS-1:0] ail_ff, ele_ff, thr_ff, rud_ff;
   logic                        flip_ff;
   logic [MAG_BITS-1:0]         ail_mag, ele_mag, thr_mag, rud_mag;
   logic [NUM_SYMBOLS-1:0][SYM_BITS-1:0] s;

   function automatic logic signed [CHAN_BITS-1:0] chan(
      input logic [MAG_BITS-1:0]           mag,
      input logic                          positive,
      input logic signed [OFFSET_BITS-1:0] off
   );
      logic signed [CHAN_BITS-1:0] m;
      m = signed'(CHAN_BITS'(mag));
      if (!positive) begin
         m = -m;
      end
      return m + CHAN_BITS'(off);
   endfunction

   function automatic logic [MAG_BITS-1:0] z(input logic [SYM_BITS-1:0] v);
      return MAG_BITS'(v);
   endfunction

   assign s = head_frame.sym;

   // symbol k of the frame sits at s[k-1]
   assign ele_mag = (z(s[1]) << 6) | (z(s[2]) << 5) | (z(s[3]) << 2) | (z(s[4]) << 1)
                  | MAG_BITS'(s[5][2]);
   assign ail_mag = (MAG_BITS'(s[5][0]) << 8) | (z(s[6]) << 7) | (z(s[7]) << 4)
                  | (z(s[8]) << 3) | z(s[9]);
   assign thr_mag = (z(s[11]) << 6) | (z(s[12]) << 5) | (z(s[13]) << 2) | (z(s[14]) << 1)
                  | MAG_BITS'(s[15][2]);
   assign rud_mag = (MAG_BITS'(s[15][0]) << 8) | (z(s[16]) << 7) | (z(s[17]) << 4)
                  | (z(s[18]) << 3) | z(s[19]);

   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ail_ff  <= chan(ail_mag, s[5][1], offsets.ail);
         ele_ff  <= chan(ele_mag, s[0] != '0, offsets.ele);
         thr_ff  <= chan(thr_mag, s[10] != '0, offsets.thr);
         rud_ff  <= chan(rud_mag, s[15][1], offsets.rud);
         flip_ff <= s[NUM_SYMBOLS-1][0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_aileron     = ail_ff;
   assign rsp_elevator    = ele_ff;
   assign rsp_throttle    = thr_ff;
   assign rsp_rudder      = rud_ff;
   assign rsp_flip_switch = flip_ff;

endmodule

// ===== rtl/rcpcm_checker.sv =====
module rcpcm_checker
   import rcpcm_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [CHAN_BITS-1:0]   rsp_aileron,
   input logic signed [CHAN_BITS-1:0]   rsp_elevator,
   input logic signed [CHAN_BITS-1:0]   rsp_throttle,
   input logic signed [CHAN_BITS-1:0]   rsp_rudder,
   input logic                          rsp_flip_switch
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // back pressure only with a result waiting
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no result waiting");

   // taking the result frees the queue at once
   a_take_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !req_ready) |=> req_ready)
      else $error("request still stalled after result taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_aileron)
         && $stable(rsp_elevator) && $stable(rsp_throttle)
         && $stable(rsp_rudder) && $stable(rsp_flip_switch)))
      else $error("stalled result changed");

endmodule

bind rc_pcm_audio_frame_decoder_unit rcpcm_checker u_checker (.*);
